/* rtl/wlsb_pkg.sv */
package wlsb_pkg;

  localparam int unsigned WindowDepth = 4;
  localparam int unsigned CntW = $clog2(WindowDepth + 1);

  typedef enum logic [1:0] {
    OpAdd     = 2'd0,
    OpCheck   = 2'd1,
    OpAck     = 2'd2,
    OpPresent = 2'd3
  } op_e;

  localparam logic [1:0] ModeW8  = 2'd0;
  localparam logic [1:0] ModeW16 = 2'd1;
  localparam logic [1:0] ModeW32 = 2'd2;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] val;
  } entry_t;

  typedef struct packed {
    logic fill;
    logic shift;
    logic ack;
  } ctrl_t;

  typedef struct packed {
    logic [31:0] value;
    logic [31:0] shift;
    logic [31:0] mask;
    logic [31:0] iw;
  } chk_t;

  typedef struct packed {
    logic   search;
    logic   found;
    logic   copy;
    entry_t copy_entry;
  } chain_t;

endpackage

/* rtl/wlsb_cell.sv */
module wlsb_cell (
  input  logic            clk_i,
  input  wlsb_pkg::ctrl_t  ctrl_i,
  input  wlsb_pkg::entry_t new_i,
  input  wlsb_pkg::entry_t prev_i,
  input  wlsb_pkg::chk_t   chk_i,
  input  logic [31:0]      sn_i,
  input  logic [31:0]      ack_bits_i,
  input  logic [31:0]      ack_mask_i,
  input  wlsb_pkg::chain_t chain_i,
  output wlsb_pkg::entry_t entry_o,
  output wlsb_pkg::chain_t chain_o,
  output logic             fail_o,
  output logic             overwrite_o
);
  import wlsb_pkg::*;

  entry_t      entry_q, entry_d;
  logic [31:0] lo, hi;
  logic        eq, gt, match;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.fill) begin
      entry_d = new_i;
    end else if (ctrl_i.shift) begin
      entry_d = prev_i;
    end else if (ctrl_i.ack && chain_i.copy) begin
      entry_d = chain_i.copy_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // interpretation interval of this reference
  always_comb begin
    lo = (entry_q.val - chk_i.shift) & chk_i.mask;
    hi = (lo + chk_i.iw) & chk_i.mask;
    if (lo <= hi) begin
      fail_o = (chk_i.value < lo) || (chk_i.value > hi);
    end else begin
      fail_o = (chk_i.value < lo) && (chk_i.value > hi);
    end
  end

  assign eq    = (sn_i == entry_q.seq);
  assign gt    = (sn_i > entry_q.seq);
  assign match = ((entry_q.seq & ack_mask_i) == ack_bits_i);

  always_comb begin
    chain_o.search     = chain_i.search & ~eq & ~gt;
    chain_o.found      = chain_i.found | (chain_i.search & eq);
    chain_o.copy       = chain_i.copy | match;
    chain_o.copy_entry = chain_i.copy ? chain_i.copy_entry : entry_q;
  end

  assign overwrite_o = chain_i.copy;
  assign entry_o     = entry_q;

endmodule

/* rtl/wlsb_reference_window.sv */
// Window of reference entries for window-based LSB encoding. The entries sit
// in a row of cells, newest first; an add shifts the row by one cell, and the
// first add after reset fills every cell. One item is accepted per cycle and
// its result appears in the output register on the next cycle; check,
// acknowledge and presence search run through the whole row of cells in the
// cycle of acceptance. The input stalls only while a finished result is held stalled.
module wlsb_reference_window (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] seq_number_i,
  input  logic [31:0] ref_value_i,
  input  logic [5:0]  bit_count_i,
  input  logic signed [31:0] shift_i,
  input  logic [31:0] ack_sn_lsbs_i,
  input  logic [5:0]  ack_bit_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        verdict_o,
  output logic [1:0]  acked_count_o
);
  import wlsb_pkg::*;

  logic [1:0]  mode_q;
  logic        filled_q, filled_d;
  logic        out_valid_q, out_valid_d;
  logic        verdict_q, verdict_d;
  logic [1:0]  acked_q, acked_d;
  logic        in_accept;
  op_e         op;
  logic [5:0]  width;
  logic [31:0] mask, ack_mask;
  ctrl_t       ctrl;
  chk_t        chk;
  entry_t      new_entry;
  entry_t      entries [WindowDepth];
  chain_t      chain [WindowDepth + 1];
  logic [WindowDepth-1:0] fail, overwrite;
  logic [CntW-1:0] cnt;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign op         = op_e'(operation_i);

  always_comb begin
    case (mode_q)
      ModeW8: begin
        width = 6'd8;
        mask  = 32'h0000_00ff;
      end
      ModeW16: begin
        width = 6'd16;
        mask  = 32'h0000_ffff;
      end
      default: begin
        width = 6'd32;
        mask  = 32'hffff_ffff;
      end
    endcase
  end

  assign ack_mask = (ack_bit_count_i >= 6'd32) ? 32'hffff_ffff
                                               : ~(32'hffff_ffff << ack_bit_count_i[4:0]);

  always_comb begin
    chk.value = ref_value_i & mask;
    chk.shift = shift_i;
    chk.mask  = mask;
    chk.iw    = ~(32'hffff_ffff << bit_count_i[4:0]) & mask;
  end

  assign new_entry.seq = seq_number_i;
  assign new_entry.val = ref_value_i;

  always_comb begin
    ctrl.fill  = in_accept && (op == OpAdd) && !filled_q;
    ctrl.shift = in_accept && (op == OpAdd) && filled_q;
    ctrl.ack   = in_accept && (op == OpAck) && filled_q;
  end

  always_comb begin
    chain[0].search     = filled_q;
    chain[0].found      = 1'b0;
    chain[0].copy       = 1'b0;
    chain[0].copy_entry = new_entry;
  end

  for (genvar g = 0; g < WindowDepth; g++) begin : g_cell
    wlsb_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .new_i       (new_entry),
      .prev_i      ((g == 0) ? new_entry : entries[(g == 0) ? 0 : g - 1]),
      .chk_i       (chk),
      .sn_i        (seq_number_i),
      .ack_bits_i  (ack_sn_lsbs_i),
      .ack_mask_i  (ack_mask),
      .chain_i     (chain[g]),
      .entry_o     (entries[g]),
      .chain_o     (chain[g + 1]),
      .fail_o      (fail[g]),
      .overwrite_o (overwrite[g])
    );
  end

  always_comb begin
    cnt = '0;
    for (int i = 0; i < WindowDepth; i++) begin
      cnt = cnt + CntW'(overwrite[i]);
    end
  end

  always_comb begin
    verdict_d = 1'b0;
    acked_d   = 2'd0;
    case (op)
      OpCheck: begin
        if (bit_count_i >= width) begin
          verdict_d = 1'b1;
        end else begin
          verdict_d = filled_q && !(|fail);
        end
      end
      OpAck: begin
        if (filled_q) begin
          acked_d = 2'(cnt);
        end
      end
      OpPresent: begin
        verdict_d = chain[WindowDepth].found;
      end
      default: begin
        verdict_d = 1'b0;
      end
    endcase
  end

  assign filled_d    = filled_q | ctrl.fill;
  assign out_valid_d = in_accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeW32;
      filled_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      filled_q    <= filled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      verdict_q <= verdict_d;
      acked_q   <= acked_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = verdict_q;
  assign acked_count_o = acked_q;

`ifndef SYNTHESIS
  a_add_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (op == OpAdd) |=> filled_q)
    else $error("window not marked filled after add");

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o)
    else $error("accepted item gave no result");

  a_count_only_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (op != OpAck) |=> (acked_count_o == 2'd0))
    else $error("acked count set outside acknowledge");

  a_empty_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !filled_q && ((op == OpAck) || (op == OpPresent))
    |=> (verdict_o == 1'b0) && (acked_count_o == 2'd0))
    else $error("empty window gave a non-zero result");
`endif

endmodule

/* test/wlsb_reference_window_tb.sv */
module wlsb_reference_window_tb;
  import wlsb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_e         op;
    logic [31:0] sn;
    logic [31:0] val;
    logic [5:0]  k;
    logic [31:0] p;
    logic [31:0] abits;
    logic [5:0]  anr;
  } item_t;

  typedef struct packed {
    logic       verdict;
    logic [1:0] acked;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  operation_i;
  logic [31:0] seq_number_i;
  logic [31:0] ref_value_i;
  logic [5:0]  bit_count_i;
  logic signed [31:0] shift_i;
  logic [31:0] ack_sn_lsbs_i;
  logic [5:0]  ack_bit_count_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        verdict_o;
  logic [1:0]  acked_count_o;

  logic [31:0] win_seq [WindowDepth];
  logic [31:0] win_val [WindowDepth];
  int unsigned win_next;
  bit          win_filled;
  logic [1:0]  width_mode;

  outcome_t    outcome_q [$];
  int unsigned fail_cnt;
  bit          sender_calm;
  bit          receiver_calm;
  bit          result_taken;
  int unsigned stall_left;

  wlsb_reference_window dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .seq_number_i   (seq_number_i),
    .ref_value_i    (ref_value_i),
    .bit_count_i    (bit_count_i),
    .shift_i        (shift_i),
    .ack_sn_lsbs_i  (ack_sn_lsbs_i),
    .ack_bit_count_i(ack_bit_count_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .verdict_o      (verdict_o),
    .acked_count_o  (acked_count_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic int unsigned field_bits();
    if (width_mode == ModeW8) return 8;
    if (width_mode == ModeW16) return 16;
    return 32;
  endfunction

  function automatic logic [31:0] field_mask();
    int unsigned w;
    w = field_bits();
    return (w >= 32) ? 32'hffff_ffff : (32'd1 << w) - 32'd1;
  endfunction

  function automatic int unsigned older(int unsigned s);
    return (s == 0) ? WindowDepth - 1 : s - 1;
  endfunction

  function automatic logic encodable(logic [31:0] value, logic [5:0] k, logic [31:0] p);
    logic [31:0] mask, iw, lo, hi;
    mask = field_mask();
    if (k >= field_bits()) return 1'b1;
    if (!win_filled) return 1'b0;
    value &= mask;
    iw = ((32'd1 << k) - 32'd1) & mask;
    for (int i = 0; i < WindowDepth; i++) begin
      lo = (win_val[i] - p) & mask;
      hi = (lo + iw) & mask;
      if (lo <= hi) begin
        if (value < lo || value > hi) return 1'b0;
      end else if (value < lo && value > hi) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [1:0] acknowledge(logic [31:0] bits, logic [5:0] nbits);
    logic [31:0] mask, cs, cv;
    int unsigned s, cnt;
    bit copying;
    mask = (nbits < 32) ? (32'd1 << nbits) - 32'd1 : 32'hffff_ffff;
    s = win_next;
    cnt = 0;
    copying = 0;
    if (!win_filled) return 2'd0;
    for (int i = 0; i < WindowDepth; i++) begin
      s = older(s);
      if (copying) begin
        win_seq[s] = cs;
        win_val[s] = cv;
        cnt++;
      end else if ((win_seq[s] & mask) == bits) begin
        copying = 1;
        cs = win_seq[s];
        cv = win_val[s];
      end
    end
    return cnt[1:0];
  endfunction

  function automatic logic sn_present(logic [31:0] sn);
    int unsigned s;
    s = win_next;
    if (!win_filled) return 1'b0;
    for (int i = 0; i < WindowDepth; i++) begin
      s = older(s);
      if (sn == win_seq[s]) return 1'b1;
      if (sn > win_seq[s]) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic outcome_t window_step(item_t it);
    outcome_t o;
    o = '0;
    case (it.op)
      OpAdd: begin
        if (!win_filled) begin
          for (int i = 0; i < WindowDepth; i++) begin
            win_seq[i] = it.sn;
            win_val[i] = it.val;
          end
          win_next = 1 % WindowDepth;
          win_filled = 1;
        end else begin
          win_seq[win_next] = it.sn;
          win_val[win_next] = it.val;
          win_next = (win_next + 1) % WindowDepth;
        end
      end
      OpCheck: o.verdict = encodable(it.val, it.k, it.p);
      OpAck: o.acked = acknowledge(it.abits, it.anr);
      default: o.verdict = sn_present(it.sn);
    endcase
    return o;
  endfunction

  function automatic item_t make_item(op_e op, logic [31:0] sn, logic [31:0] val,
                                      logic [5:0] k, logic [31:0] p,
                                      logic [31:0] abits, logic [5:0] anr);
    item_t it;
    it.op = op;
    it.sn = sn;
    it.val = val;
    it.k = k;
    it.p = p;
    it.abits = abits;
    it.anr = anr;
    return it;
  endfunction

  function automatic item_t shaped_item();
    item_t it;
    logic [31:0] mask, amask, base;
    int unsigned j, sel;
    int delta;
    mask = field_mask();
    j = $urandom_range(0, WindowDepth - 1);
    it = make_item(op_e'($urandom_range(0, 3)), $urandom, $urandom,
                   6'($urandom_range(0, 32)), $urandom, $urandom,
                   6'($urandom_range(0, 32)));
    if ($urandom_range(0, 99) < 12) return it;
    sel = $urandom_range(0, 9);
    if (sel < 3) begin
      it.op = OpAdd;
      base = win_val[older(win_next)];
      if ($urandom_range(0, 9) != 0) it.sn = win_seq[older(win_next)] + $urandom_range(1, 4);
      if ($urandom_range(0, 7) != 0) begin
        delta = int'($urandom_range(0, 6)) - 3;
        it.val = ($urandom & ~mask) | ((base + delta) & mask);
      end
    end else if (sel < 6) begin
      it.op = OpCheck;
      case ($urandom_range(0, 5))
        0: it.p = 32'h8000_0000;
        1: it.p = 32'h7fff_ffff;
        2: it.p = $urandom;
        default: begin
          delta = int'($urandom_range(0, 8)) - 4;
          it.p = delta;
        end
      endcase
      if ($urandom_range(0, 3) != 0) it.k = 6'($urandom_range(0, field_bits()));
      base = win_val[j] - it.p + (($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 20));
      it.val = ($urandom & ~mask) | (base & mask);
    end else if (sel < 8) begin
      it.op = OpAck;
      amask = (it.anr < 32) ? (32'd1 << it.anr) - 32'd1 : 32'hffff_ffff;
      it.abits = win_seq[j] & amask;
      if ($urandom_range(0, 5) == 0) it.abits ^= 32'd1 << $urandom_range(0, 31);
    end else begin
      it.op = OpPresent;
      case ($urandom_range(0, 7))
        0: it.sn = win_seq[j] + 32'd1;
        1: it.sn = win_seq[j] - 32'd1;
        2: it.sn = $urandom;
        default: it.sn = win_seq[j];
      endcase
    end
    return it;
  endfunction

  task automatic send_item(input item_t it);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 13);
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i     <= it.op;
    seq_number_i    <= it.sn;
    ref_value_i     <= it.val;
    bit_count_i     <= it.k;
    shift_i         <= it.p;
    ack_sn_lsbs_i   <= it.abits;
    ack_bit_count_i <= it.anr;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    outcome_q.push_back(window_step(it));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_width_mode(input logic [1:0] m);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= m;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    width_mode = m;
  endtask

  task automatic test_empty_window();
    send_item(make_item(OpCheck, 32'd0, 32'h1234_5678, 6'd5, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpCheck, 32'd0, 32'hffff_ffff, 6'd32, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpAck, 32'd0, 32'd0, 6'd0, 32'd0, 32'd0, 6'd32));
    send_item(make_item(OpPresent, 32'd0, 32'd0, 6'd0, 32'd0, 32'd0, 6'd0));
    set_width_mode(ModeW8);
    send_item(make_item(OpCheck, 32'd0, 32'h55, 6'd8, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpCheck, 32'd0, 32'h55, 6'd0, 32'd0, 32'd0, 6'd0));
    set_width_mode(ModeW32);
  endtask

  task automatic test_fill_and_present();
    send_item(make_item(OpAdd, 32'd100, 32'hffff_ffff, 6'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpPresent, 32'd100, 32'd0, 6'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpPresent, 32'd50, 32'd0, 6'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpAdd, 32'hffff_ffff, 32'd0, 6'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpAdd, 32'd200, 32'h7fff_ffff, 6'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpPresent, 32'd200, 32'd0, 6'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpPresent, 32'hffff_ffff, 32'd0, 6'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpPresent, 32'd100, 32'd0, 6'd0, 32'd0, 32'd0, 6'd0));
  endtask

  task automatic test_check_extremes();
    send_item(make_item(OpCheck, 32'd0, 32'd0, 6'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpCheck, 32'd0, 32'haaaa_aaaa, 6'd31, 32'h8000_0000, 32'd0, 6'd0));
    send_item(make_item(OpCheck, 32'd0, 32'h7fff_ffff, 6'd20, 32'h7fff_ffff, 32'd0, 6'd0));
    send_item(make_item(OpCheck, 32'd0, 32'h0f0f_0f0f, 6'd32, 32'hffff_ffff, 32'd0, 6'd0));
  endtask

  task automatic test_ack_cases();
    send_item(make_item(OpAck, 32'd0, 32'd0, 6'd0, 32'd0, 32'hffff_ffff, 6'd32));
    send_item(make_item(OpAck, 32'd0, 32'd0, 6'd0, 32'd0, 32'h0000_0100, 6'd4));
    send_item(make_item(OpAck, 32'd0, 32'd0, 6'd0, 32'd0, 32'd0, 6'd0));
    send_item(make_item(OpAck, 32'd0, 32'd0, 6'd0, 32'd0, 32'd0, 6'd0));
  endtask

  task automatic test_random_stream(input logic [1:0] m, input int unsigned n);
    set_width_mode(m);
    repeat (n) send_item(shaped_item());
  endtask

  // hold stall for a drawn number of cycles before each result
  always @(negedge clk_i) begin
    if (result_taken) begin
      result_taken = 0;
      stall_left = receiver_calm ? 0 : $urandom_range(0, 13);
      if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    outcome_t want, got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      result_taken = 1;
      got = {verdict_o, acked_count_o};
      if (outcome_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected item: verdict %0b acked_count %0d", verdict_o, acked_count_o);
      end else begin
        want = outcome_q.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: verdict exp %0b got %0b, acked_count exp %0d got %0d",
                     want.verdict, got.verdict, want.acked, got.acked);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("wlsb_reference_window test failed");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = ModeW32;
    in_valid_i      = 1'b0;
    out_stall_i     = 1'b0;
    operation_i     = OpAdd;
    seq_number_i    = '0;
    ref_value_i     = '0;
    bit_count_i     = '0;
    shift_i         = '0;
    ack_sn_lsbs_i   = '0;
    ack_bit_count_i = '0;
    for (int i = 0; i < WindowDepth; i++) begin
      win_seq[i] = '0;
      win_val[i] = '0;
    end
    win_next      = 0;
    win_filled    = 0;
    width_mode    = ModeW32;
    fail_cnt      = 0;
    sender_calm   = 0;
    receiver_calm = 0;
    result_taken  = 0;
    stall_left    = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_window();
    test_fill_and_present();
    test_check_extremes();
    test_ack_cases();
    test_random_stream(ModeW32, 200);
    test_random_stream(ModeW8, 200);
    test_random_stream(ModeW16, 200);
    test_random_stream(2'd3, 160);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0 && outcome_q.size() == 0) begin
      $display("wlsb_reference_window test passed");
    end else begin
      $display("wlsb_reference_window test failed");
    end
    $finish;
  end

endmodule

/* wlsb_reference_window.f */
rtl/wlsb_pkg.sv
rtl/wlsb_cell.sv
rtl/wlsb_reference_window.sv
test/wlsb_reference_window_tb.sv
